### sv/htfd_pkg.sv
// Shared constants, types and the CRC-8 byte update for the frame decoder.
package htfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Byte positions within a six-byte frame
  localparam logic [2:0] PosTempHi = 3'd0;
  localparam logic [2:0] PosTempLo = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumHi = 3'd3;
  localparam logic [2:0] PosHumLo = 3'd4;
  localparam logic [2:0] PosHumCrc = 3'd5;

  // Scaling: value = floor(raw * Scale / 65535) - Offset
  localparam int unsigned TempProdW = 31;
  localparam int unsigned HumProdW = 30;
  localparam logic [TempProdW-1:0] TempScale = 31'd17500;
  localparam logic [HumProdW-1:0] HumScale = 30'd10000;
  localparam logic signed [15:0] TempOffset = 16'sd4500;

  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        ok;
  } frame_rec_t;

  typedef struct packed {
    logic [TempProdW-1:0] temp_prod;
    logic [HumProdW-1:0]  hum_prod;
    logic                 ok;
  } prod_rec_t;

  // CRC-8, MSB first, no reflection, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/htfd_frame.sv
// Input register, frame position tracking, CRC checking and word capture.
module htfd_frame (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_rdy_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_start_i,
  output logic                rec_vld_o,
  input  logic                rec_rdy_i,
  output htfd_pkg::frame_rec_t rec_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] tw_q, tw_d;
  logic [15:0] hw_q, hw_d;
  logic        fok_q, fok_d;

  logic                 rec_vld_q;
  htfd_pkg::frame_rec_t rec_q;

  logic last, consume;

  assign pos  = (in_start_q || (pos_q > htfd_pkg::PosHumCrc)) ? htfd_pkg::PosTempHi : pos_q;
  assign last = (pos == htfd_pkg::PosHumCrc);
  // only the final byte needs room downstream
  assign consume  = in_vld_q && (!last || !rec_vld_q || rec_rdy_i);
  assign in_rdy_o = !in_vld_q || consume;

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    tw_d  = tw_q;
    hw_d  = hw_q;
    fok_d = fok_q;
    unique case (pos)
      htfd_pkg::PosTempHi: begin
        crc_d = htfd_pkg::crc8_byte(htfd_pkg::CrcInit, in_byte_q);
        tw_d  = {in_byte_q, 8'h00};
        pos_d = htfd_pkg::PosTempLo;
      end
      htfd_pkg::PosTempLo: begin
        crc_d = htfd_pkg::crc8_byte(crc_q, in_byte_q);
        tw_d  = {tw_q[15:8], in_byte_q};
        pos_d = htfd_pkg::PosTempCrc;
      end
      htfd_pkg::PosTempCrc: begin
        fok_d = (crc_q == in_byte_q);
        crc_d = htfd_pkg::CrcInit;
        pos_d = htfd_pkg::PosHumHi;
      end
      htfd_pkg::PosHumHi: begin
        crc_d = htfd_pkg::crc8_byte(htfd_pkg::CrcInit, in_byte_q);
        hw_d  = {in_byte_q, 8'h00};
        pos_d = htfd_pkg::PosHumLo;
      end
      htfd_pkg::PosHumLo: begin
        crc_d = htfd_pkg::crc8_byte(crc_q, in_byte_q);
        hw_d  = {hw_q[15:8], in_byte_q};
        pos_d = htfd_pkg::PosHumCrc;
      end
      default: begin
        crc_d = htfd_pkg::CrcInit;
        fok_d = 1'b0;
        pos_d = htfd_pkg::PosTempHi;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pos_q     <= htfd_pkg::PosTempHi;
      crc_q     <= htfd_pkg::CrcInit;
      fok_q     <= 1'b0;
      rec_vld_q <= 1'b0;
    end else begin
      if (in_rdy_o) begin
        in_vld_q <= in_valid_i;
      end
      if (consume) begin
        pos_q <= pos_d;
        crc_q <= crc_d;
        fok_q <= fok_d;
      end
      if (consume && last) begin
        rec_vld_q <= 1'b1;
      end else if (rec_rdy_i) begin
        rec_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o) begin
      in_byte_q  <= rx_byte_i;
      in_start_q <= frame_start_i;
    end
    if (consume) begin
      tw_q <= tw_d;
      hw_q <= hw_d;
    end
    if (consume && last) begin
      rec_q.temp_word <= tw_q;
      rec_q.hum_word  <= hw_q;
      rec_q.ok        <= fok_q && (crc_q == in_byte_q);
    end
  end

  assign rec_vld_o = rec_vld_q;
  assign rec_o     = rec_q;

endmodule

### sv/htfd_scale.sv
// Two-stage scaling: constant products, then divide by 65535 and offset.
module htfd_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rec_vld_i,
  output logic                       rec_rdy_o,
  input  htfd_pkg::frame_rec_t       rec_i,
  output logic                       res_vld_o,
  input  logic                       res_stall_i,
  output logic signed [14:0]         temp_o,
  output logic [13:0]                hum_o,
  output logic                       ok_o
);

  logic                mul_vld_q;
  htfd_pkg::prod_rec_t mul_q;
  logic                mul_rdy;

  logic               res_vld_q;
  logic               res_rdy;
  logic signed [14:0] temp_q;
  logic [13:0]        hum_q;
  logic               ok_q;

  logic [31:0]        tsum;
  logic [30:0]        hsum;
  logic [14:0]        tq;
  logic [13:0]        hq;
  logic signed [15:0] tdiff;

  assign res_rdy   = !res_vld_q || !res_stall_i;
  assign mul_rdy   = !mul_vld_q || res_rdy;
  assign rec_rdy_o = mul_rdy;

  // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 while the quotient stays below 2^16
  assign tsum  = 32'(mul_q.temp_prod) + 32'(mul_q.temp_prod[30:16]) + 32'd1;
  assign hsum  = 31'(mul_q.hum_prod) + 31'(mul_q.hum_prod[29:16]) + 31'd1;
  assign tq    = tsum[30:16];
  assign hq    = hsum[29:16];
  assign tdiff = signed'({1'b0, tq}) - htfd_pkg::TempOffset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (mul_rdy) begin
        mul_vld_q <= rec_vld_i;
      end
      if (res_rdy) begin
        res_vld_q <= mul_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy && rec_vld_i) begin
      mul_q.temp_prod <= {{(htfd_pkg::TempProdW-16){1'b0}}, rec_i.temp_word}
                         * htfd_pkg::TempScale;
      mul_q.hum_prod  <= {{(htfd_pkg::HumProdW-16){1'b0}}, rec_i.hum_word}
                         * htfd_pkg::HumScale;
      mul_q.ok        <= rec_i.ok;
    end
    if (res_rdy && mul_vld_q) begin
      temp_q <= mul_q.ok ? tdiff[14:0] : 15'sd0;
      hum_q  <= mul_q.ok ? hq : 14'd0;
      ok_q   <= mul_q.ok;
    end
  end

  assign res_vld_o = res_vld_q;
  assign temp_o    = temp_q;
  assign hum_o     = hum_q;
  assign ok_o      = ok_q;

endmodule

### sv/humidity_temp_frame_decoder_top.sv
// Top level of the temperature and humidity readout frame decoder.
// Takes one readout byte per transaction, one transaction per clock when the
// output is not stalled: temperature high, low, CRC, humidity high, low, CRC.
// Each word is checked with CRC-8 (poly 0x31, init 0xFF). After the sixth byte
// a single result transaction carries temperature in hundredths of a degree C
// and humidity in hundredths of a percent; on any CRC mismatch both are zero
// and checks_ok is clear. frame_start on a byte drops any partial frame and
// treats that byte as the first. Throughput is one byte per cycle unless a
// frame's sixth byte waits for room in the frame record. A result passes the
// input, frame record, product and result registers. Every stage holds its
// own transaction, so non-final bytes flow on while a result waits to be taken.
module humidity_temp_frame_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] temperature_centi_c_o,
  output logic [13:0]        humidity_centi_pct_o,
  output logic               checks_ok_o
);

  logic                 in_rdy;
  logic                 rec_vld;
  logic                 rec_rdy;
  htfd_pkg::frame_rec_t rec;

  // Byte stage: CRC, word capture, position counter
  htfd_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_rdy_o      (in_rdy),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .rec_vld_o     (rec_vld),
    .rec_rdy_i     (rec_rdy),
    .rec_o         (rec)
  );

  // Scaling stages: multiply, then divide by 65535 and apply offset
  htfd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_vld_i   (rec_vld),
    .rec_rdy_o   (rec_rdy),
    .rec_i       (rec),
    .res_vld_o   (out_valid_o),
    .res_stall_i (out_stall_i),
    .temp_o      (temperature_centi_c_o),
    .hum_o       (humidity_centi_pct_o),
    .ok_o        (checks_ok_o)
  );

  assign in_stall_o = !in_rdy;

endmodule
